FILE: design/klex_pkg.sv
package klex_pkg;

  localparam int unsigned VALUE_BITS = 31;
  // Level bounds reach limit+1, so counting runs one bit wider.
  localparam int unsigned CNT_BITS   = VALUE_BITS + 1;
  // A bound times ten needs four more bits.
  localparam int unsigned MUL_BITS   = CNT_BITS + 4;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [MUL_BITS-1:0]   mul_t;

  typedef struct packed {
    logic start;
    cnt_t prefix;
  } cnt_req_t;

  typedef struct packed {
    logic done;
    cnt_t size;
  } cnt_rsp_t;

  // x * 10 as (x << 3) + (x << 1).
  function automatic mul_t times_ten(input cnt_t x);
    mul_t ext;
    ext = {{(MUL_BITS - CNT_BITS){1'b0}}, x};
    return (ext << 3) + (ext << 1);
  endfunction

endpackage

FILE: design/kth_lexicographic_integer.sv
// k-th integer of 1..limit in decimal string order, by a walk of the prefix tree.
// Each walk step waits on the shared subtree counter, which counts one tree level
// of the current prefix per cycle.
// Throughput: one transaction at a time; a new one is taken once the result has
// been loaded into the output register, where it may still wait to be taken.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module kth_lexicographic_integer import klex_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  value_t limit_i,
  input  value_t rank_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output value_t answer_o,
  output logic   invalid_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_WAIT,
    S_DONE
  } walk_state_e;

  walk_state_e state_q;
  value_t      limit_q, left_q, answer_q;
  cnt_t        cur_q;
  logic        inv_q, invalid_q, out_valid_q;

  cnt_req_t cnt_req;
  cnt_rsp_t cnt_rsp;
  logic     in_acc, out_load;
  mul_t     cur10;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign cur10      = times_ten(cur_q);

  assign cnt_req.start  = (state_q == S_WALK) && (left_q != '0);
  assign cnt_req.prefix = cur_q;

  klex_subtree u_subtree (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .lim_i (limit_q),
    .req_i (cnt_req),
    .rsp_o (cnt_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= '0;
      left_q      <= '0;
      cur_q       <= '0;
      inv_q       <= 1'b0;
      answer_q    <= '0;
      invalid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        answer_q    <= cur_q[VALUE_BITS-1:0];
        invalid_q   <= inv_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            limit_q <= limit_i;
            if (rank_i == '0 || rank_i > limit_i) begin
              cur_q   <= '0;
              inv_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              // prefix 1 itself is the first number
              left_q  <= rank_i - value_t'(1);
              cur_q   <= cnt_t'(1);
              inv_q   <= 1'b0;
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          state_q <= (left_q == '0) ? S_DONE : S_WAIT;
        end
        S_WAIT: begin
          if (cnt_rsp.done) begin
            if (cnt_rsp.size <= {1'b0, left_q}) begin
              // skip the whole subtree, advance to the next sibling
              left_q <= left_q - cnt_rsp.size[VALUE_BITS-1:0];
              cur_q  <= cur_q + cnt_t'(1);
            end else begin
              // descend to the first child
              left_q <= left_q - value_t'(1);
              cur_q  <= cur10[CNT_BITS-1:0];
            end
            state_q <= S_WALK;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;
  assign invalid_o   = invalid_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> answer_o == '0)
    else $error("invalid result carries a nonzero answer");

  a_count_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_rsp.done |-> state_q == S_WAIT)
    else $error("subtree count finished outside the wait state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready right after an accepted transaction");

  a_start_only_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_req.start |=> state_q == S_WAIT)
    else $error("count started without waiting for it");

endmodule

FILE: design/klex_subtree.sv
module klex_subtree import klex_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  value_t   lim_i,
  input  cnt_req_t req_i,
  output cnt_rsp_t rsp_o
);

  typedef enum logic {
    C_IDLE,
    C_RUN
  } cnt_state_e;

  cnt_state_e state_q;
  cnt_t       lo_q, hi_q, total_q;
  logic       done_q;

  cnt_t cap;
  cnt_t top;
  mul_t lo10, hi10, lim_ext;

  assign cap     = {1'b0, lim_i} + cnt_t'(1);
  assign top     = (hi_q < cap) ? hi_q : cap;
  assign lo10    = times_ten(lo_q);
  assign hi10    = times_ten(hi_q);
  assign lim_ext = {{(MUL_BITS - VALUE_BITS){1'b0}}, lim_i};

  // One level of the prefix subtree per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            lo_q    <= req_i.prefix;
            hi_q    <= req_i.prefix + cnt_t'(1);
            total_q <= '0;
            state_q <= C_RUN;
          end
        end
        C_RUN: begin
          if (lo_q < cap) begin
            total_q <= total_q + (top - lo_q);
            if (lo10 > lim_ext) begin
              // next level starts above the limit
              state_q <= C_IDLE;
              done_q  <= 1'b1;
            end else begin
              lo_q <= lo10[CNT_BITS-1:0];
              hi_q <= (hi10 > lim_ext) ? cap : hi10[CNT_BITS-1:0];
            end
          end else begin
            state_q <= C_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.size = total_q;

endmodule

FILE: bench/tb_kth_lexicographic_integer.sv
`timescale 1ns / 1ps

module tb_kth_lexicographic_integer;
  import klex_pkg::*;

  localparam int unsigned          RANDOM_QUERIES = 1700;
  localparam longint unsigned      RADIX          = 10;
  localparam value_t               VALUE_MAX      = '1;
  localparam longint unsigned      CYCLE_LIMIT    = 10_000_000;
  localparam int unsigned          DRAIN_CYCLES   = 50;
  localparam int unsigned          IDLE_PERCENT   = 13;
  localparam int unsigned          QUIET_FROM     = 700;
  localparam int unsigned          QUIET_TO       = 1000;

  typedef struct packed {
    value_t limit;
    value_t rank;
  } query_t;

  typedef struct packed {
    value_t answer;
    logic   invalid;
  } verdict_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  value_t limit_i     = '0;
  value_t rank_i      = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  value_t answer_o;
  logic   invalid_o;

  query_t          queued_queries[$];
  verdict_t        awaited_answers[$];
  verdict_t        oldest_answer;
  int unsigned     sent_cnt;
  int unsigned     seen_cnt;
  int unsigned     mismatch_cnt;
  longint unsigned cycle_cnt = 0;

  kth_lexicographic_integer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .limit_i     (limit_i),
    .rank_i      (rank_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .answer_o    (answer_o),
    .invalid_o   (invalid_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Count of numbers up to lim that start with the decimal prefix lo.
  function automatic longint unsigned prefix_span(longint unsigned lim,
                                                  longint unsigned lo);
    longint unsigned hi;
    longint unsigned cap;
    longint unsigned tenth;
    longint unsigned top;
    longint unsigned total;
    hi    = lo + 1;
    cap   = lim + 1;
    tenth = lim / RADIX;
    total = 0;
    while (lo <= lim) begin
      top   = (hi < cap) ? hi : cap;
      total += top - lo;
      if (lo > tenth) break;
      lo = lo * RADIX;
      // clamp the upper bound once it passes the limit
      if (hi > tenth) hi = cap;
      else hi = hi * RADIX;
    end
    return total;
  endfunction

  function automatic verdict_t kth_in_dict_order(value_t limit, value_t rank);
    verdict_t        v;
    longint unsigned lim;
    longint unsigned left;
    longint unsigned node;
    longint unsigned span;
    lim  = limit;
    left = rank;
    node = 1;
    v    = '0;
    if (left == 0 || left > lim) begin
      v.invalid = 1'b1;
      return v;
    end
    left = left - 1;
    while (left > 0) begin
      span = prefix_span(lim, node);
      // skip the whole subtree, or descend into its first child
      if (span <= left) begin
        left = left - span;
        node = node + 1;
      end else begin
        node = node * RADIX;
        left = left - 1;
      end
    end
    v.answer = node[VALUE_BITS-1:0];
    return v;
  endfunction

  task automatic add_query(value_t limit, value_t rank);
    query_t q;
    q.limit = limit;
    q.rank  = rank;
    queued_queries.push_back(q);
  endtask

  function automatic value_t random_limit();
    int unsigned bits;
    int unsigned v;
    bits = $urandom_range(VALUE_BITS, 1);
    v    = $urandom & ((32'd1 << bits) - 1);
    v    = v | (32'd1 << (bits - 1));
    return v[VALUE_BITS-1:0];
  endfunction

  function automatic bit idle_now(int unsigned done_cnt);
    if (done_cnt >= QUIET_FROM && done_cnt < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PERCENT;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sent_cnt   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        awaited_answers.push_back(kth_in_dict_order(limit_i, rank_i));
        sent_cnt <= sent_cnt + 1;
      end
      if (queued_queries.size() > 0 && !idle_now(sent_cnt)) begin
        query_t q;
        q = queued_queries.pop_front();
        limit_i    <= q.limit;
        rank_i     <= q.rank;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      seen_cnt     <= 0;
      mismatch_cnt <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_cnt <= seen_cnt + 1;
        if (awaited_answers.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected transaction: answer=%0d invalid=%0b", answer_o, invalid_o);
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          oldest_answer = awaited_answers.pop_front();
          if (answer_o !== oldest_answer.answer || invalid_o !== oldest_answer.invalid) begin
            if (mismatch_cnt < 10)
              $display("mismatch #%0d: answer exp %0d got %0d, invalid exp %0b got %0b",
                       seen_cnt, oldest_answer.answer, answer_o,
                       oldest_answer.invalid, invalid_o);
            mismatch_cnt <= mismatch_cnt + 1;
          end
        end
      end
      out_ready_i <= !idle_now(seen_cnt);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_kth_lexicographic_integer: errors");
      $finish;
    end
  end

  initial begin
    value_t limit;
    value_t rank;
    int unsigned pick;

    // edges of the range, rank zero, rank past the limit, limit zero
    add_query(1, 1);
    add_query(0, 0);
    add_query(0, 1);
    add_query(1, 0);
    add_query(1, 2);
    add_query(9, 9);
    add_query(10, 2);
    add_query(13, 2);
    add_query(13, 5);
    add_query(13, 6);
    add_query(10, 11);
    add_query(100, 3);
    add_query(100, 100);
    add_query(999_999_999, 123_456_789);
    add_query(1_000_000_000, 1_000_000_000);
    add_query(2_000_000_000, 1_999_999_999);
    add_query(VALUE_MAX, 0);
    add_query(VALUE_MAX, 1);
    add_query(VALUE_MAX, value_t'(VALUE_MAX - 1));
    add_query(VALUE_MAX, VALUE_MAX);
    add_query(value_t'(VALUE_MAX - 1), VALUE_MAX);

    for (int unsigned i = 0; i < RANDOM_QUERIES; i++) begin
      pick  = $urandom_range(99);
      limit = random_limit();
      if (pick < 3) begin
        limit = '0;
        rank  = value_t'($urandom_range(1, 0));
      end else if (pick < 6) begin
        rank = '0;
      end else if (pick < 10 && limit != VALUE_MAX) begin
        rank = value_t'($urandom_range(VALUE_MAX, limit + 1));
      end else if (pick < 14) begin
        // ends of the valid rank range
        rank = pick[0] ? limit : value_t'(1);
      end else begin
        rank = value_t'($urandom_range(limit, 1));
      end
      add_query(limit, rank);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (queued_queries.size() > 0 || in_valid_i || awaited_answers.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("tb_kth_lexicographic_integer: clean");
    end else begin
      $display("tb_kth_lexicographic_integer: errors");
    end
    $finish;
  end

endmodule
